FILE: src/x86md_pkg.sv
// ----------------------------------------------------------------------------
// x86md_pkg
// Shared types, operation codes and helpers for the multiply/divide pipeline.
// ----------------------------------------------------------------------------
package x86md_pkg;

    localparam logic [1:0] CMD_MUL  = 2'd0;
    localparam logic [1:0] CMD_IMUL = 2'd1;
    localparam logic [1:0] CMD_DIV  = 2'd2;
    localparam logic [1:0] CMD_IDIV = 2'd3;

    localparam logic [15:0] QUO_LIMIT_BYTE_U = 16'd255;
    localparam logic [15:0] QUO_LIMIT_BYTE_S = 16'd127;
    localparam logic [15:0] QUO_LIMIT_WORD_S = 16'd32767;

    // Quotient bits resolved in each divide stage, and the number of those stages.
    localparam int unsigned BITS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES     = 16 / BITS_PER_STAGE;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        wide;
        logic [15:0] ax;
        logic [15:0] dx;
        logic [15:0] src;
        logic [31:0] prod;   // product, low 32 bits
        logic [15:0] rem;    // partial remainder
        logic [15:0] dvd;    // dividend bits still to shift in, msb first
        logic [15:0] quo;    // quotient bits collected so far
        logic [15:0] dmag;   // divisor magnitude
        logic        qneg;   // quotient must be negated
        logic        rneg;   // remainder must be negated
        logic        err;    // divide error already known
    } item_t;

    // One restoring division step: returns {quotient bit, new remainder}.
    // The step is exact only if the incoming remainder is below the divisor.
    function automatic logic [16:0] div_step(input logic [15:0] rem,
                                             input logic        bit_in,
                                             input logic [15:0] dmag);
        logic [16:0] trial;
        logic [16:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, dmag};
        if (trial >= {1'b0, dmag}) begin
            div_step = {1'b1, diff[15:0]};
        end else begin
            div_step = {1'b0, trial[15:0]};
        end
    endfunction

endpackage

FILE: src/x86_multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// x86_multiply_divide_unit
// Pipelined 8086 MUL, IMUL, DIV and IDIV in byte and word size.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_ channel carries one instruction (operation,
// size, AX, DX and the fetched source operand). Each produces exactly one
// transfer on the m_ channel with the new AX and DX, the CF/OF value and a
// divide-error flag; on a divide error AX and DX come back unchanged.
// Throughput is one instruction per cycle while the receiver keeps up: a new
// item can enter each cycle and passes through a chain of seven registered
// stages (input capture, operand preparation with the multiplier, four divide
// stages of four restoring steps each, and result formatting into the output
// register).
// When the receiver stalls (m_tready low with a result waiting) the full stages
// ahead hold while empty stages behind them still fill; s_tready drops once
// every stage is full. Nothing is lost or repeated. Reset clears all valid bits
// synchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
module x86_multiply_divide_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] cmd, [2] wide, [18:3] acc_low, [34:19] acc_high,
    // [50:35] operand, [55:51] zero
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] new_ax, [31:16] new_dx, [32] carry_overflow,
    // [33] divide_error, [39:34] zero
    output logic [39:0] m_tdata
);

    localparam int unsigned NSTG = x86md_pkg::DIV_STAGES + 2;

    // Stage 0 is input capture, stage 1 preparation, the rest divide steps.
    x86md_pkg::item_t stg_reg [0:NSTG-1];
    x86md_pkg::item_t stg_next [0:NSTG-1];
    logic             vld_reg [0:NSTG];
    logic             adv [0:NSTG];
    logic [39:0]      out_reg;
    logic [39:0]      out_next;

    // A stage loads when its successor advances or when it is itself empty.
    always_comb begin
        adv[NSTG] = !vld_reg[NSTG] || m_tready;
        for (int i = NSTG - 1; i >= 0; i--) begin
            adv[i] = adv[i + 1] || !vld_reg[i];
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NSTG];
    assign m_tdata  = out_reg;

    // Stage 0: unpack the input transfer.
    always_comb begin
        stg_next[0]      = '0;
        stg_next[0].cmd  = s_tdata[1:0];
        stg_next[0].wide = s_tdata[2];
        stg_next[0].ax   = s_tdata[18:3];
        stg_next[0].dx   = s_tdata[34:19];
        stg_next[0].src  = s_tdata[50:35];
    end

    // Stage 1: multiply, and set up magnitudes and the early divide checks.
    logic        p_signed;
    logic [16:0] p_a;
    logic [16:0] p_b;
    logic [33:0] p_prod;
    logic [31:0] p_n;
    logic [15:0] p_d;
    logic [31:0] p_nmag;
    logic [15:0] p_dmag;

    always_comb begin
        x86md_pkg::item_t it;
        it       = stg_reg[0];
        p_signed = it.cmd[0];
        if (it.wide) begin
            p_a = {p_signed & it.ax[15], it.ax};
            p_b = {p_signed & it.src[15], it.src};
            p_n = {it.dx, it.ax};
            p_d = it.src;
        end else begin
            p_a = {{9{p_signed & it.ax[7]}}, it.ax[7:0]};
            p_b = {{9{p_signed & it.src[7]}}, it.src[7:0]};
            p_n = {{16{p_signed & it.ax[15]}}, it.ax};
            p_d = {{8{p_signed & it.src[7]}}, it.src[7:0]};
        end
        p_prod = 34'($signed(p_a) * $signed(p_b));
        p_nmag = (p_signed && p_n[31]) ? (32'd0 - p_n) : p_n;
        p_dmag = (p_signed && p_d[15]) ? (16'd0 - p_d) : p_d;

        it.prod = p_prod[31:0];
        it.rem  = p_nmag[31:16];
        it.dvd  = p_nmag[15:0];
        it.quo  = '0;
        it.dmag = p_dmag;
        it.qneg = p_signed && (p_n[31] ^ p_d[15]);
        it.rneg = p_signed && p_n[31];
        // A zero divisor, or a high half not below the divisor, means the
        // quotient cannot fit in 16 bits.
        it.err  = (p_dmag == 16'd0) || (p_nmag[31:16] >= p_dmag);
        stg_next[1] = it;
    end

    // Divide stages: four restoring steps each.
    for (genvar s = 2; s < NSTG; s++) begin : g_div_stage
        always_comb begin
            x86md_pkg::item_t it;
            logic [16:0]      st;
            it = stg_reg[s - 1];
            for (int k = 0; k < x86md_pkg::BITS_PER_STAGE; k++) begin
                st     = x86md_pkg::div_step(it.rem, it.dvd[15], it.dmag);
                it.rem = st[15:0];
                it.dvd = {it.dvd[14:0], 1'b0};
                it.quo = {it.quo[14:0], st[16]};
            end
            stg_next[s] = it;
        end
    end

    // Final stage: flags, signs, limits and result packing.
    logic [15:0] f_q;
    logic [15:0] f_r;
    logic [15:0] f_ax;
    logic [15:0] f_dx;
    logic        f_cf;
    logic        f_err;

    always_comb begin
        x86md_pkg::item_t it;
        it    = stg_reg[NSTG - 1];
        f_q   = it.qneg ? (16'd0 - it.quo) : it.quo;
        f_r   = it.rneg ? (16'd0 - it.rem) : it.rem;
        f_ax  = it.ax;
        f_dx  = it.dx;
        f_cf  = 1'b0;
        f_err = 1'b0;
        case (it.cmd)
            x86md_pkg::CMD_MUL: begin
                f_ax = it.prod[15:0];
                if (it.wide) begin
                    f_dx = it.prod[31:16];
                    f_cf = it.prod[31:16] != 16'd0;
                end else begin
                    f_cf = it.prod[15:8] != 8'd0;
                end
            end
            x86md_pkg::CMD_IMUL: begin
                f_ax = it.prod[15:0];
                if (it.wide) begin
                    f_dx = it.prod[31:16];
                    f_cf = it.prod[31:16] != {16{it.prod[15]}};
                end else begin
                    f_cf = it.prod[15:8] != {8{it.prod[7]}};
                end
            end
            x86md_pkg::CMD_DIV: begin
                f_err = it.err || (!it.wide && it.quo > x86md_pkg::QUO_LIMIT_BYTE_U);
            end
            default: begin
                f_err = it.err || (it.wide ? (it.quo > x86md_pkg::QUO_LIMIT_WORD_S)
                                           : (it.quo > x86md_pkg::QUO_LIMIT_BYTE_S));
            end
        endcase
        if (it.cmd[1] && !f_err) begin
            if (it.wide) begin
                f_ax = f_q;
                f_dx = f_r;
            end else begin
                f_ax = {f_r[7:0], f_q[7:0]};
            end
        end
        out_next = {6'd0, f_err, f_cf, f_dx, f_ax};
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= NSTG; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i <= NSTG; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i - 1];
                end
            end
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSTG; i++) begin
            if (adv[i]) begin
                stg_reg[i] <= stg_next[i];
            end
        end
        if (adv[NSTG]) begin
            out_reg <= out_next;
        end
    end

endmodule
